FILE: src/yaw_pitch_camera_basis_defines.svh
// Assertion macros shared by the camera basis RTL.
// Depends on nothing; the including module must declare clk and rst_n.
`ifndef YAW_PITCH_CAMERA_BASIS_DEFINES_SVH
`define YAW_PITCH_CAMERA_BASIS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YPCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define YPCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ypcb_pkg.sv
// Types, constants and small functions for the yaw/pitch camera basis block.
// Used by ypcb_sincos and yaw_pitch_camera_basis; depends on nothing.
package ypcb_pkg;

  localparam int ANGLE_FRAC_BITS  = 8;
  localparam int VECTOR_FRAC_BITS = 14;

  localparam int DEG_1   = 1 << ANGLE_FRAC_BITS;
  localparam int DEG_45  = 45 * DEG_1;
  localparam int DEG_89  = 89 * DEG_1;
  localparam int DEG_90  = 90 * DEG_1;
  localparam int DEG_180 = 180 * DEG_1;
  localparam int DEG_270 = 270 * DEG_1;
  localparam int DEG_360 = 360 * DEG_1;

  // Bias that makes any yaw or pitch sum non-negative before the modulo pass.
  localparam int WRAP_BIAS  = DEG_180 + 183 * DEG_360;
  localparam int WRAP_STEPS = 8;

  localparam logic [31:0] RAD_PER_DEG_Q32 = 32'd74961321;
  localparam int TV_SHIFT = 32 - VECTOR_FRAC_BITS;

  localparam logic [15:0] SENS_RESET = 16'd4588;
  localparam logic signed [16:0] YAW_RESET = -17'sd23040;

  localparam logic signed [17:0] VEC_ONE = 18'(1 << VECTOR_FRAC_BITS);

  typedef enum logic [1:0] {
    CFG_SENS        = 2'd0,
    CFG_START_YAW   = 2'd1,
    CFG_START_PITCH = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    T_IDLE, T_INCX, T_WRAPY, T_INCY, T_WRAPP, T_TRIGY, T_TRIGP,
    T_FX, T_FZ, T_UX, T_UZ, T_UY1, T_UY2, T_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    SC_IDLE, SC_X, SC_X2, SC_MS, SC_DS, SC_MC, SC_DC, SC_FIN, SC_DONE
  } sc_state_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } sc_result_t;

  // Divisor n(n-1) of Taylor term k for sine or cosine.
  function automatic logic [7:0] term_div(input logic is_cos, input logic [2:0] k);
    logic [7:0] d;
    case ({is_cos, k})
      4'b0001: d = 8'd6;
      4'b0010: d = 8'd20;
      4'b0011: d = 8'd42;
      4'b0100: d = 8'd72;
      4'b0101: d = 8'd110;
      4'b0110: d = 8'd156;
      4'b1001: d = 8'd2;
      4'b1010: d = 8'd12;
      4'b1011: d = 8'd30;
      4'b1100: d = 8'd56;
      4'b1101: d = 8'd90;
      4'b1110: d = 8'd132;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // Saturates a vector component to plus or minus one.
  function automatic logic [15:0] sat_vec(input logic signed [17:0] v);
    logic signed [17:0] c;
    if (v > VEC_ONE) c = VEC_ONE;
    else if (v < -VEC_ONE) c = -VEC_ONE;
    else c = v;
    return c[15:0];
  endfunction

endpackage

FILE: src/ypcb_sincos.sv
// Sine and cosine of a wrapped Q.8 degree angle by Taylor series, Q1.14 results.
// One shared multiplier and a bit-serial divider; depends on ypcb_pkg.
module ypcb_sincos import ypcb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] angle,
  output sc_result_t         res
);

  sc_state_t state_r, state_nxt;

  logic [1:0]  quad_r;
  logic        swap_r;
  logic [13:0] red_r;
  logic [31:0] x_r, x2_r, ts_r, dq_r;
  logic [32:0] tc_r, ss_r, sc_r;
  logic [2:0]  k_r;
  logic [7:0]  rem_r;
  logic [4:0]  bit_r;
  logic signed [15:0] sin_r, cos_r;

  // Angle reduction to quadrant and remainder.
  logic [16:0] n_ang;
  logic [14:0] r_ang;
  logic [1:0]  q_ang;
  logic        sw_ang;
  logic [13:0] red_ang;

  always_comb begin
    n_ang = angle[16] ? 17'(angle) + 17'(DEG_360) : 17'(angle);
    if (n_ang >= 17'(DEG_270)) begin
      q_ang = 2'd3;
      r_ang = 15'(n_ang - 17'(DEG_270));
    end else if (n_ang >= 17'(DEG_180)) begin
      q_ang = 2'd2;
      r_ang = 15'(n_ang - 17'(DEG_180));
    end else if (n_ang >= 17'(DEG_90)) begin
      q_ang = 2'd1;
      r_ang = 15'(n_ang - 17'(DEG_90));
    end else begin
      q_ang = 2'd0;
      r_ang = n_ang[14:0];
    end
    sw_ang  = r_ang > 15'(DEG_45);
    red_ang = sw_ang ? 14'(15'(DEG_90) - r_ang) : r_ang[13:0];
  end

  // Shared multiplier, operands picked by state.
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;

  always_comb begin
    case (state_r)
      SC_X: begin
        mul_a = {19'd0, red_r};
        mul_b = RAD_PER_DEG_Q32;
      end
      SC_X2: begin
        mul_a = {1'b0, x_r};
        mul_b = x_r;
      end
      SC_MS: begin
        mul_a = {1'b0, ts_r};
        mul_b = x2_r;
      end
      default: begin
        mul_a = tc_r;
        mul_b = x2_r;
      end
    endcase
    prod = 65'(mul_a) * 65'(mul_b);
  end

  // Restoring divider, one quotient bit per cycle.
  logic [7:0]  dvs;
  logic [8:0]  r9;
  logic        ge;
  logic [7:0]  rem_nxt;
  logic [31:0] dq_nxt;

  always_comb begin
    dvs     = term_div(state_r == SC_DC, k_r);
    r9      = {rem_r, dq_r[31]};
    ge      = r9 >= {1'b0, dvs};
    rem_nxt = ge ? 8'(r9 - {1'b0, dvs}) : r9[7:0];
    dq_nxt  = {dq_r[30:0], ge};
  end

  // Final rounding and quadrant mapping.
  logic signed [15:0] s_v, c_v, s_sw, c_sw, sin_f, cos_f;

  always_comb begin
    s_v  = 16'((ss_r + (33'd1 << (TV_SHIFT - 1))) >> TV_SHIFT);
    c_v  = 16'((sc_r + (33'd1 << (TV_SHIFT - 1))) >> TV_SHIFT);
    s_sw = swap_r ? c_v : s_v;
    c_sw = swap_r ? s_v : c_v;
    case (quad_r)
      2'd0: begin sin_f = s_sw;  cos_f = c_sw;  end
      2'd1: begin sin_f = c_sw;  cos_f = -s_sw; end
      2'd2: begin sin_f = -s_sw; cos_f = -c_sw; end
      default: begin sin_f = -c_sw; cos_f = s_sw; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= SC_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE: if (start) state_nxt = SC_X;
      SC_X:    state_nxt = SC_X2;
      SC_X2:   state_nxt = SC_MS;
      SC_MS:   state_nxt = SC_DS;
      SC_DS:   if (bit_r == 5'd31) state_nxt = SC_MC;
      SC_MC:   state_nxt = SC_DC;
      SC_DC: begin
        if (bit_r == 5'd31) state_nxt = (k_r == 3'd6) ? SC_FIN : SC_MS;
      end
      SC_FIN:  state_nxt = SC_DONE;
      SC_DONE: state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      SC_IDLE: begin
        quad_r <= q_ang;
        swap_r <= sw_ang;
        red_r  <= red_ang;
      end
      SC_X: x_r <= prod[39:8];
      SC_X2: begin
        x2_r <= prod[63:32];
        ts_r <= x_r;
        ss_r <= {1'b0, x_r};
        tc_r <= 33'd1 << 32;
        sc_r <= 33'd1 << 32;
        k_r  <= 3'd1;
      end
      SC_MS, SC_MC: begin
        dq_r  <= prod[63:32];
        rem_r <= 8'd0;
        bit_r <= 5'd0;
      end
      SC_DS, SC_DC: begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        bit_r <= bit_r + 5'd1;
        if (bit_r == 5'd31) begin
          if (state_r == SC_DS) begin
            ts_r <= dq_nxt;
            ss_r <= k_r[0] ? ss_r - {1'b0, dq_nxt} : ss_r + {1'b0, dq_nxt};
          end else begin
            tc_r <= {1'b0, dq_nxt};
            sc_r <= k_r[0] ? sc_r - {1'b0, dq_nxt} : sc_r + {1'b0, dq_nxt};
            k_r  <= k_r + 3'd1;
          end
        end
      end
      SC_FIN: begin
        sin_r <= sin_f;
        cos_r <= cos_f;
      end
      default: ;
    endcase
  end

  assign res.done  = (state_r == SC_DONE);
  assign res.sin_v = sin_r;
  assign res.cos_v = cos_r;

endmodule

FILE: src/yaw_pitch_camera_basis.sv
// Top level of the mouse-driven yaw/pitch camera basis block.
// Depends on ypcb_pkg, ypcb_sincos and yaw_pitch_camera_basis_defines.svh.
//
// Usage:
// Each transaction on the in_ stream carries x/y mouse deltas, a scroll
// delta and the pitch-constrain flag. The block updates yaw, pitch and
// field of view, then returns one transaction on the out_ stream with the
// front, right and up vectors in Q1.14, the new angles and the degenerate
// flag. The cfg_ channel writes sensitivity and the start angles; a start
// angle write also loads the live angle. Write config only while idle.
// One item needs a 9-step modulo pass for yaw, one more for pitch unless
// pitch is constrained, and, above all, two sine/cosine runs, each twelve
// Taylor terms whose divisions go one quotient bit per cycle. One item is
// worked on at a time; in_tready rises again once the result is loaded into
// the output register, so the next item can start while that result waits.
// When the receiver stalls, a second result waits in its last step until the
// output register frees.
// Synchronous reset loads yaw -90 degrees, pitch 0, field of view 45
// degrees and the default sensitivity, and empties the output register.
`include "yaw_pitch_camera_basis_defines.svh"
module yaw_pitch_camera_basis import ypcb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // x_offset[15:0], y_offset[31:16], scroll_offset[39:32]
  input  logic [39:0]  in_tdata,
  // constrain_pitch[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // front_x[15:0], front_y[31:16], front_z[47:32], right_x[63:48],
  // right_z[79:64], up_x[95:80], up_y[111:96], up_z[127:112],
  // yaw_now[144:128], pitch_now[161:145], fov_now[175:162]
  output logic [175:0] out_tdata,
  // degenerate[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  top_state_t state_r, state_nxt;

  logic [15:0]        sens_r;
  logic signed [16:0] yaw_r, pitch_r;
  logic [13:0]        fov_r;
  logic signed [15:0] xo_r, yo_r;
  logic signed [7:0]  so_r;
  logic               con_r;
  logic [24:0]        wrap_r;
  logic [3:0]         kw_r;
  logic signed [15:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [16:0] fx_r, fz_r, ux_r, uz_r;
  logic signed [17:0] uy_r;
  logic signed [33:0] acc_r;
  logic               out_tvalid_r;
  logic [175:0]       out_data_r;
  logic               out_degen_r;

  logic       sc_start;
  logic       load_out;
  sc_result_t sc_res;
  logic signed [16:0] sc_angle;

  assign sc_angle = (state_r == T_TRIGP) ? pitch_r : yaw_r;

  ypcb_sincos u_sincos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .angle (sc_angle),
    .res   (sc_res)
  );

  // Right vector carries the sign of cos pitch.
  logic               cp_neg, degen;
  logic signed [16:0] rx, rz;

  always_comb begin
    cp_neg = cp_r < 0;
    degen  = (cp_r == 16'sd0);
    rx     = cp_neg ? 17'(sy_r) : -17'(sy_r);
    rz     = cp_neg ? -17'(cy_r) : 17'(cy_r);
  end

  // Shared signed multiplier.
  logic signed [16:0] ma, mb;
  logic signed [33:0] mp;

  always_comb begin
    case (state_r)
      T_INCX:  begin ma = 17'(xo_r); mb = $signed({1'b0, sens_r}); end
      T_INCY:  begin ma = 17'(yo_r); mb = $signed({1'b0, sens_r}); end
      T_FX:    begin ma = 17'(cy_r); mb = 17'(cp_r); end
      T_FZ:    begin ma = 17'(sy_r); mb = 17'(cp_r); end
      T_UX:    begin ma = -rz;       mb = 17'(sp_r); end
      T_UZ:    begin ma = rx;        mb = 17'(sp_r); end
      T_UY1:   begin ma = rz;        mb = fx_r; end
      default: begin ma = rx;        mb = fz_r; end
    endcase
    mp = 34'(ma) * 34'(mb);
  end

  // Angle increment rounded half up, plus angle sums.
  logic signed [33:0] mp_r8, mp_r14;
  logic signed [34:0] uy_sum;
  logic signed [26:0] inc, ysum, psum, wrap_in;
  logic signed [16:0] pclamp;

  always_comb begin
    mp_r8   = mp + 34'sd128;
    mp_r14  = mp + 34'sd8192;
    uy_sum  = 35'(acc_r) - 35'(mp) + 35'sd8192;
    inc     = 27'($signed(mp_r8[33:8]));
    ysum    = 27'(yaw_r) + inc;
    psum    = 27'(pitch_r) + inc;
    wrap_in = ((state_r == T_INCX) ? ysum : psum) + 27'(WRAP_BIAS);
    if (psum > 27'(DEG_89)) pclamp = 17'(DEG_89);
    else if (psum < -27'(DEG_89)) pclamp = -17'(DEG_89);
    else pclamp = 17'(psum);
  end

  // Modulo pass: one compare and subtract of 360 degrees times 2^k per cycle.
  logic [24:0] wrap_cmp, wrap_nxt;

  always_comb begin
    wrap_cmp = 25'(DEG_360) << kw_r;
    wrap_nxt = (wrap_r >= wrap_cmp) ? wrap_r - wrap_cmp : wrap_r;
  end

  // Field of view update.
  logic signed [16:0] fov_d;
  logic [13:0]        fov_new;

  always_comb begin
    fov_d = $signed({3'b000, fov_r}) - (17'(so_r) <<< ANGLE_FRAC_BITS);
    if (fov_d < 17'(DEG_1)) fov_new = 14'(DEG_1);
    else if (fov_d > 17'(DEG_45)) fov_new = 14'(DEG_45);
    else fov_new = fov_d[13:0];
  end

  // Start angle written through a single wrap into [-180,180).
  logic signed [17:0] cw_t, cw_w;
  logic signed [16:0] cw_res;

  always_comb begin
    cw_t = 18'($signed(cfg_data)) + 18'(DEG_180);
    if (cw_t < 0) cw_w = cw_t + 18'(DEG_360);
    else if (cw_t >= 18'(DEG_360)) cw_w = cw_t - 18'(DEG_360);
    else cw_w = cw_t;
    cw_res = 17'(cw_w - 18'(DEG_180));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= T_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    sc_start  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      T_IDLE:  if (in_tvalid) state_nxt = T_INCX;
      T_INCX:  state_nxt = T_WRAPY;
      T_WRAPY: if (kw_r == 4'd0) state_nxt = T_INCY;
      T_INCY:  state_nxt = con_r ? T_TRIGY : T_WRAPP;
      T_WRAPP: if (kw_r == 4'd0) state_nxt = T_TRIGY;
      T_TRIGY: begin
        sc_start = 1'b1;
        if (sc_res.done) state_nxt = T_TRIGP;
      end
      T_TRIGP: begin
        sc_start = 1'b1;
        if (sc_res.done) state_nxt = T_FX;
      end
      T_FX:    state_nxt = T_FZ;
      T_FZ:    state_nxt = T_UX;
      T_UX:    state_nxt = T_UZ;
      T_UZ:    state_nxt = T_UY1;
      T_UY1:   state_nxt = T_UY2;
      T_UY2:   state_nxt = T_OUT;
      T_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  // Control state and the angle registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r       <= SENS_RESET;
      yaw_r        <= YAW_RESET;
      pitch_r      <= 17'sd0;
      fov_r        <= 14'(DEG_45);
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SENS:        sens_r  <= cfg_data[15:0];
          CFG_START_YAW:   yaw_r   <= cw_res;
          CFG_START_PITCH: pitch_r <= cw_res;
          default: ;
        endcase
      end
      if (state_r == T_INCX) fov_r <= fov_new;
      if (state_r == T_WRAPY && kw_r == 4'd0) yaw_r <= 17'(wrap_nxt - 25'(DEG_180));
      if (state_r == T_WRAPP && kw_r == 4'd0) pitch_r <= 17'(wrap_nxt - 25'(DEG_180));
      if (state_r == T_INCY && con_r) pitch_r <= pclamp;
      if (load_out) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      T_IDLE: begin
        xo_r  <= $signed(in_tdata[15:0]);
        yo_r  <= $signed(in_tdata[31:16]);
        so_r  <= $signed(in_tdata[39:32]);
        con_r <= in_tuser[0];
      end
      T_INCX, T_INCY: begin
        wrap_r <= wrap_in[24:0];
        kw_r   <= 4'(WRAP_STEPS);
      end
      T_WRAPY, T_WRAPP: begin
        wrap_r <= wrap_nxt;
        kw_r   <= kw_r - 4'd1;
      end
      T_TRIGY: if (sc_res.done) begin
        sy_r <= sc_res.sin_v;
        cy_r <= sc_res.cos_v;
      end
      T_TRIGP: if (sc_res.done) begin
        sp_r <= sc_res.sin_v;
        cp_r <= sc_res.cos_v;
      end
      T_FX:  fx_r  <= 17'(mp_r14[33:14]);
      T_FZ:  fz_r  <= 17'(mp_r14[33:14]);
      T_UX:  ux_r  <= 17'(mp_r14[33:14]);
      T_UZ:  uz_r  <= 17'(mp_r14[33:14]);
      T_UY1: acc_r <= mp;
      T_UY2: uy_r  <= 18'(uy_sum[34:14]);
      default: ;
    endcase
    if (load_out) begin
      out_degen_r <= degen;
      out_data_r  <= {fov_r, pitch_r, yaw_r,
                      degen ? 16'd0 : sat_vec(18'(uz_r)),
                      degen ? 16'd0 : sat_vec(uy_r),
                      degen ? 16'd0 : sat_vec(18'(ux_r)),
                      degen ? 16'd0 : sat_vec(18'(rz)),
                      degen ? 16'd0 : sat_vec(18'(rx)),
                      sat_vec(18'(fz_r)),
                      sat_vec(18'(sp_r)),
                      sat_vec(18'(fx_r))};
    end
  end

  assign in_tready    = (state_r == T_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_degen_r;

  `YPCB_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `YPCB_ASSERT_NOW(a_degen_right_zero, out_tvalid && out_tuser[0], out_tdata[79:48] == 32'd0, "degenerate result has nonzero right vector")
  `YPCB_ASSERT_NOW(a_fov_range, out_tvalid, out_tdata[175:162] >= 14'd256 && out_tdata[175:162] <= 14'd11520, "field of view out of range")
  `YPCB_ASSERT_NOW(a_yaw_range, out_tvalid, $signed(out_tdata[144:128]) >= -17'sd46080, "yaw below range")
  `YPCB_ASSERT_NOW(a_sc_only_in_trig, sc_res.done, state_r == T_TRIGY || state_r == T_TRIGP, "trig result outside trig step")

endmodule

FILE: verif/yaw_pitch_camera_basis_tb.sv
// Self-checking testbench for the yaw/pitch camera basis block: mouse events go in
// on the in_ stream and each result is checked against an in-bench angle and vector model.
// Depends on ypcb_pkg and the yaw_pitch_camera_basis RTL.
module yaw_pitch_camera_basis_tb;
  import ypcb_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index, must be ignored
  localparam int CYCLE_LIMIT = 8000000;

  typedef struct {
    logic [15:0] x_off;
    logic [15:0] y_off;
    logic [7:0]  scroll;
    logic        constrain;
  } mouse_event_t;

  typedef struct {
    logic [15:0] vec [8];
    logic [16:0] yaw;
    logic [16:0] pitch;
    logic [13:0] fov;
    logic        degen;
  } basis_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [16:0]  cfg_data = '0;

  mouse_event_t event_q[$];
  basis_t       basis_q[$];
  mouse_event_t cur_event;
  int           errors = 0;
  int           checked = 0;
  int           degen_seen = 0;
  int           cycles = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  bit           calm = 1'b0;
  logic         hold_out = 1'b0;

  // Model state.
  longint sens_r, yaw_r, pitch_r, fov_r;

  yaw_pitch_camera_basis DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint wrap360(longint v);
    longint r;
    r = (v + DEG_180) % DEG_360;
    if (r < 0) r += DEG_360;
    return r - DEG_180;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void trig(input longint a, output longint sn, output longint cs);
    longint n, q, r, s, c, t;
    longint unsigned x, x2, ts, ss, tc, sc;
    bit swap;
    n = a % DEG_360;
    if (n < 0) n += DEG_360;
    q = n / DEG_90;
    r = n % DEG_90;
    swap = (2 * r > DEG_90);
    if (swap) r = DEG_90 - r;
    x = (longint'(r) * longint'(RAD_PER_DEG_Q32)) >> ANGLE_FRAC_BITS;
    x2 = (x * x) >> 32;
    ts = x; ss = x; tc = 64'd1 << 32; sc = tc;
    for (int k = 1; k <= 6; k++) begin
      ts = ((ts * x2) >> 32) / longint'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 32) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss -= ts; sc -= tc;
      end else begin
        ss += ts; sc += tc;
      end
    end
    s = longint'((ss + (64'd1 << (TV_SHIFT - 1))) >> TV_SHIFT);
    c = longint'((sc + (64'd1 << (TV_SHIFT - 1))) >> TV_SHIFT);
    if (swap) begin
      t = s; s = c; c = t;
    end
    case (q)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic [15:0] clip_vec(longint v);
    longint one;
    one = 64'sd1 <<< VECTOR_FRAC_BITS;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[15:0];
  endfunction

  // Advances the camera state by one mouse event and returns the new basis.
  function automatic basis_t advance_camera(mouse_event_t ev);
    basis_t b;
    longint sy, cy, sp, cp, fx, fy, fz, rx, rz, ux, uy, uz, sg, v[8];
    yaw_r = wrap360(yaw_r + rnd_shift(longint'($signed(ev.x_off)) * sens_r,
                                      16 - ANGLE_FRAC_BITS));
    pitch_r += rnd_shift(longint'($signed(ev.y_off)) * sens_r, 16 - ANGLE_FRAC_BITS);
    if (ev.constrain) begin
      if (pitch_r > DEG_89) pitch_r = DEG_89;
      if (pitch_r < -DEG_89) pitch_r = -DEG_89;
    end else begin
      pitch_r = wrap360(pitch_r);
    end
    fov_r = fov_r - longint'($signed(ev.scroll)) * DEG_1;
    if (fov_r < DEG_1) fov_r = DEG_1;
    if (fov_r > DEG_45) fov_r = DEG_45;
    trig(yaw_r, sy, cy);
    trig(pitch_r, sp, cp);
    fx = rnd_shift(cy * cp, VECTOR_FRAC_BITS);
    fy = sp;
    fz = rnd_shift(sy * cp, VECTOR_FRAC_BITS);
    rx = 0; rz = 0; ux = 0; uy = 0; uz = 0;
    b.degen = (cp == 0);
    if (!b.degen) begin
      sg = (cp > 0) ? 1 : -1;
      rx = -sy * sg;
      rz = cy * sg;
      ux = rnd_shift(-rz * fy, VECTOR_FRAC_BITS);
      uy = rnd_shift(rz * fx - rx * fz, VECTOR_FRAC_BITS);
      uz = rnd_shift(rx * fy, VECTOR_FRAC_BITS);
    end
    v = '{fx, fy, fz, rx, rz, ux, uy, uz};
    foreach (v[i]) b.vec[i] = clip_vec(v[i]);
    b.yaw = yaw_r[16:0];
    b.pitch = pitch_r[16:0];
    b.fov = fov_r[13:0];
    return b;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("ERROR result %0d: %s = %0d, expected %0d", checked, what, got, want);
  endtask

  // Sender: takes events from the pending queue, with random idle bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) basis_q.push_back(advance_camera(cur_event));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (event_q.size() > 0) begin
          cur_event = event_q.pop_front();
          in_tdata <= {cur_event.scroll, cur_event.y_off, cur_event.x_off};
          in_tuser <= cur_event.constrain;
          in_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    basis_t got, want;
    string names[8];
    names = '{"front_x", "front_y", "front_z", "right_x", "right_z", "up_x", "up_y", "up_z"};
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        foreach (got.vec[i]) got.vec[i] = out_tdata[16 * i +: 16];
        got.yaw = out_tdata[144:128];
        got.pitch = out_tdata[161:145];
        got.fov = out_tdata[175:162];
        got.degen = out_tuser[0];
        checked++;
        if (basis_q.size() == 0) begin
          errors++;
          $display("ERROR result %0d arrived with nothing expected", checked);
        end else begin
          want = basis_q.pop_front();
          foreach (want.vec[i])
            if (got.vec[i] !== want.vec[i])
              report(names[i], $signed(got.vec[i]), $signed(want.vec[i]));
          if (got.yaw !== want.yaw) report("yaw_now", $signed(got.yaw), $signed(want.yaw));
          if (got.pitch !== want.pitch)
            report("pitch_now", $signed(got.pitch), $signed(want.pitch));
          if (got.fov !== want.fov) report("fov_now", got.fov, want.fov);
          if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
          if (want.degen) degen_seen++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= !hold_out;
      end
    end
  end

  // Long receiver hold-off so the output register and the pipeline back up.
  initial begin
    @(posedge clk);
    while (checked < 30) @(posedge clk);
    hold_out <= 1'b1;
    for (int i = 0; i < 4000; i++) @(posedge clk);
    hold_out <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles, basis_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [16:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SENS: sens_r = value[15:0];
      CFG_START_YAW: yaw_r = wrap360(longint'($signed(value)));
      CFG_START_PITCH: pitch_r = wrap360(longint'($signed(value)));
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk);
    while (event_q.size() > 0 || in_tvalid || basis_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_event(int x, int y, int s, bit c);
    mouse_event_t ev;
    ev.x_off = x[15:0];
    ev.y_off = y[15:0];
    ev.scroll = s[7:0];
    ev.constrain = c;
    event_q.push_back(ev);
  endtask

  // Small mouse motion and full-range deltas in equal measure, to hit clamps and wraps.
  task automatic queue_random(int n);
    mouse_event_t ev;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) begin
        ev.x_off = 16'($signed($urandom_range(0, 128)) - 64);
        ev.y_off = 16'($signed($urandom_range(0, 128)) - 64);
        ev.scroll = 8'($signed($urandom_range(0, 6)) - 3);
      end else begin
        ev.x_off = 16'($urandom);
        ev.y_off = 16'($urandom);
        ev.scroll = 8'($urandom);
      end
      ev.constrain = 1'($urandom_range(0, 1));
      event_q.push_back(ev);
    end
  endtask

  initial begin
    sens_r = SENS_RESET;
    yaw_r = YAW_RESET;
    pitch_r = 0;
    fov_r = DEG_45;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes under reset settings, then the field of view walked to both limits.
    queue_event(0, 0, 0, 0);
    queue_event(32767, 0, 0, 0);
    queue_event(-32768, 0, 0, 1);
    queue_event(0, 32767, 0, 1);
    queue_event(0, -32768, 0, 1);
    queue_event(0, 32767, 0, 0);
    queue_event(0, -32768, 127, 0);
    queue_event(0, 0, 127, 1);
    queue_event(0, 0, -128, 0);
    queue_event(-1, -1, -1, 1);
    queue_event(1, 1, 1, 0);
    drain();

    // Zero sensitivity with pitch sitting exactly on the vertical in both directions.
    write_reg(CFG_SENS, 17'd0);
    write_reg(CFG_START_YAW, 17'd65535);
    write_reg(CFG_START_PITCH, 17'(DEG_90));
    queue_event(12345, -7, 5, 0);
    queue_event(-32768, 32767, -5, 0);
    drain();
    write_reg(CFG_START_PITCH, 17'(-DEG_90));
    queue_event(0, 0, 0, 0);
    queue_event(0, 0, 0, 1);
    drain();
    write_reg(CFG_START_PITCH, 17'(DEG_270));
    queue_event(0, 0, 0, 0);
    drain();

    // Largest sensitivity and an out-of-range start yaw; the spare index must do nothing.
    write_reg(CFG_SENS, 17'h1FFFF);
    write_reg(CFG_START_YAW, 17'h10000);
    write_reg(CFG_START_PITCH, 17'd46079);
    write_reg(CFG_SPARE, 17'h15555);
    queue_event(32767, 32767, 0, 0);
    queue_event(-32768, -32768, 0, 0);
    queue_event(3, -3, 0, 1);
    queue_random(300);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_SENS, phase == 0 ? 17'(SENS_RESET) : 17'($urandom));
      write_reg(CFG_START_YAW, 17'($urandom));
      write_reg(CFG_START_PITCH, 17'($urandom));
      if ($urandom_range(0, 1)) write_reg(CFG_SPARE, 17'($urandom));
      queue_random(300);
      drain();
    end

    calm = 1'b1;
    write_reg(CFG_SENS, 17'd1);
    queue_random(280);
    drain();

    $display("Checked %0d results over several sensitivity and start-angle settings,",
             checked);
    $display("%0d of them with pitch on the vertical.", degen_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/ypcb_pkg.sv
src/ypcb_sincos.sv
src/yaw_pitch_camera_basis.sv
verif/yaw_pitch_camera_basis_tb.sv
